// ===== rtl/gzmhp_pkg.sv =====
// Shared constants and types for the gzip member header parser.
package gzmhp_pkg;

  // Header field values.
  localparam logic [7:0] MAGIC0         = 8'h1f;
  localparam logic [7:0] MAGIC1         = 8'h8b;
  localparam logic [7:0] METHOD_DEFLATE = 8'd8;

  // Bit positions in the FLG byte.
  localparam int FLG_FHCRC    = 1;
  localparam int FLG_FEXTRA   = 2;
  localparam int FLG_FNAME    = 3;
  localparam int FLG_FCOMMENT = 4;

  // Field lengths in bytes.
  localparam int FIXED_LEN   = 10;
  localparam int HCRC_LEN    = 2;
  localparam int TRAILER_LEN = 8;

  // Byte classification codes.
  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_TRAILER = 2'd2;
  localparam logic [1:0] KIND_DISCARD = 2'd3;

  // Status codes.
  localparam logic [1:0] STAT_RUN       = 2'd0;
  localparam logic [1:0] STAT_REJECT    = 2'd1;
  localparam logic [1:0] STAT_END_OPEN  = 2'd2;
  localparam logic [1:0] STAT_END_CLEAN = 2'd3;

  // Result queue geometry.
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  // One classified byte.
  typedef struct packed {
    logic [7:0] data;
    logic [1:0] kind;
    logic       plain;
    logic       done;
    logic [7:0] flags;
    logic [1:0] status;
    logic       last;
  } gzmhp_res_t;

  // Results of one accepted input byte, handed to the result queue.
  typedef struct packed {
    logic [1:0] n;
    gzmhp_res_t r0;
    gzmhp_res_t r1;
  } gzmhp_push_t;

endpackage

// ===== rtl/gzip_member_header_parser.sv =====
// Top level of the gzip member header parser: stream ports, parser core and result queue.
// Timing: each result is registered in the result queue and presented from there; the first
// byte of the file is held and enters the queue together with the second byte.
// Throughput: one input byte per cycle while the queue has room; the first two bytes give
// two results in one transaction, which the four-entry result queue absorbs.
// Reset: synchronous, active low; the parser returns to awaiting the first byte, queue empty.
module gzip_member_header_parser
  import gzmhp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte
  input  logic        in_tuser,   // member_end
  input  logic        in_tlast,   // end_of_input
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // data_out[7:0], member_flags[15:8], status[17:16], zeros
  output logic [3:0]  out_tuser,  // byte_kind[1:0], is_plain[2], header_done[3]
  output logic        out_tlast   // last_of_run
);

  logic        acc;
  logic        room;
  gzmhp_push_t push;
  gzmhp_res_t  head;

  // Input is taken whenever the queue can hold the largest burst of one transaction, so the
  // parser keeps going while earlier results still wait on the output side.
  assign in_tready = room;
  assign acc       = in_tvalid && in_tready;

  // The core classifies each accepted byte in the same cycle and updates its state.
  gzmhp_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (acc),
    .in_byte (in_tdata),
    .mend    (in_tuser),
    .eoi     (in_tlast),
    .push    (push)
  );

  // The queue registers every result and presents them in order.
  gzmhp_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .pop        (out_tready),
    .head       (head),
    .head_valid (out_tvalid),
    .room       (room)
  );

  // Pack the head result onto the output stream.
  assign out_tdata = {6'b0, head.status, head.flags, head.data};
  assign out_tuser = {head.done, head.plain, head.kind};
  assign out_tlast = head.last;

endmodule

// ===== rtl/gzmhp_core.sv =====
// Mode detection and header parsing state, classifying each accepted byte (the first is held until the second).
module gzmhp_core
  import gzmhp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        acc,
  input  logic [7:0]  in_byte,
  input  logic        mend,
  input  logic        eoi,
  output gzmhp_push_t push
);

  typedef enum logic [3:0] {
    MODE_FIRST  = 4'b0001,
    MODE_SECOND = 4'b0010,
    MODE_GZIP   = 4'b0100,
    MODE_PLAIN  = 4'b1000
  } mode_t;

  typedef enum logic [8:0] {
    PH_FIXED   = 9'b000000001,
    PH_XLEN0   = 9'b000000010,
    PH_XLEN1   = 9'b000000100,
    PH_EXTRA   = 9'b000001000,
    PH_NAME    = 9'b000010000,
    PH_COMMENT = 9'b000100000,
    PH_HCRC    = 9'b001000000,
    PH_PAYLOAD = 9'b010000000,
    PH_TRAILER = 9'b100000000
  } phase_t;

  typedef struct packed {
    mode_t       mode;
    logic [7:0]  held;
    phase_t      phase;
    logic [15:0] cnt;
    logic [7:0]  flags;
    logic [7:0]  xlo;
    logic        hvalid;
    logic        stopped;
  } st_t;

  typedef struct packed {
    st_t        s;
    logic [1:0] kind;
    logic       done;
  } step_t;

  st_t st_r, st_nxt;

  // Next optional field after the one of rank lvl (0 fixed, 1 extra, 2 name, 3 comment, 4 crc).
  function automatic phase_t phase_after(logic [2:0] lvl, logic [7:0] f);
    phase_t p;
    if (lvl == 3'd0 && f[FLG_FEXTRA]) p = PH_XLEN0;
    else if (lvl <= 3'd1 && f[FLG_FNAME]) p = PH_NAME;
    else if (lvl <= 3'd2 && f[FLG_FCOMMENT]) p = PH_COMMENT;
    else if (lvl <= 3'd3 && f[FLG_FHCRC]) p = PH_HCRC;
    else p = PH_PAYLOAD;
    return p;
  endfunction

  function automatic step_t advance(step_t o, logic [2:0] lvl);
    step_t r;
    r         = o;
    r.s.phase = phase_after(lvl, o.s.flags);
    r.s.cnt   = '0;
    r.done    = (r.s.phase == PH_PAYLOAD);
    return r;
  endfunction

  function automatic logic [1:0] status_of(st_t s);
    logic [1:0] st;
    if (!s.stopped) st = STAT_RUN;
    else if (s.mode != MODE_GZIP) st = STAT_END_CLEAN;
    else if (!s.hvalid) st = STAT_REJECT;
    else if (s.phase == PH_PAYLOAD || (s.phase == PH_FIXED && s.cnt == 16'd0))
      st = STAT_END_CLEAN;
    else st = STAT_END_OPEN;
    return st;
  endfunction

  function automatic gzmhp_res_t make_res(st_t s, logic [7:0] b, logic [1:0] kind,
                                          logic done);
    gzmhp_res_t r;
    r.data   = b;
    r.kind   = kind;
    r.plain  = (s.mode == MODE_PLAIN);
    r.done   = done;
    r.flags  = s.flags;
    r.status = status_of(s);
    r.last   = 1'b0;
    return r;
  endfunction

  // One byte through the gzip header/payload/trailer parser.
  function automatic step_t gz_step(st_t s, logic [7:0] b, logic me, logic eo);
    step_t       o;
    logic [15:0] inc;
    logic [15:0] dec;
    logic [15:0] len;
    o      = '0;
    o.s    = s;
    o.kind = KIND_HEADER;
    o.done = 1'b0;
    inc    = s.cnt + 16'd1;
    dec    = s.cnt - 16'd1;
    len    = {b, s.xlo};
    if (s.stopped) begin
      o.kind = KIND_DISCARD;
    end else begin
      unique case (s.phase)
        PH_FIXED: begin
          if ((s.cnt == 16'd0 && b != MAGIC0) ||
              (s.cnt == 16'd1 && b != MAGIC1) ||
              (s.cnt == 16'd2 && b != METHOD_DEFLATE))
            o.s.hvalid = 1'b0;
          if (s.cnt == 16'd3) o.s.flags = b;
          o.s.cnt = inc;
          if (inc >= 16'(FIXED_LEN)) begin
            if (!o.s.hvalid) o.s.stopped = 1'b1;
            else o = advance(o, 3'd0);
          end
        end
        PH_XLEN0: begin
          o.s.xlo   = b;
          o.s.phase = PH_XLEN1;
        end
        PH_XLEN1: begin
          o.s.cnt = len;
          if (len == 16'd0) o = advance(o, 3'd1);
          else o.s.phase = PH_EXTRA;
        end
        PH_EXTRA: begin
          o.s.cnt = dec;
          if (dec == 16'd0) o = advance(o, 3'd1);
        end
        PH_NAME: begin
          if (b == 8'd0) o = advance(o, 3'd2);
        end
        PH_COMMENT: begin
          if (b == 8'd0) o = advance(o, 3'd3);
        end
        PH_HCRC: begin
          o.s.cnt = inc;
          if (inc >= 16'(HCRC_LEN)) o = advance(o, 3'd4);
        end
        PH_TRAILER: begin
          o.kind  = KIND_TRAILER;
          o.s.cnt = inc;
          if (inc >= 16'(TRAILER_LEN)) begin
            o.s.phase  = PH_FIXED;
            o.s.cnt    = '0;
            o.s.hvalid = 1'b1;
          end
        end
        default: begin
          if (me) begin
            o.kind    = KIND_TRAILER;
            o.s.phase = PH_TRAILER;
            o.s.cnt   = 16'd1;
          end else begin
            o.kind = KIND_PAYLOAD;
          end
        end
      endcase
      if (eo) o.s.stopped = 1'b1;
    end
    return o;
  endfunction

  always_comb begin
    st_t   gs_in;
    step_t g;
    gs_in = st_r;
    if (st_r.mode == MODE_SECOND) begin
      // The held magic byte has already been taken as the first header byte.
      gs_in.mode = MODE_GZIP;
      gs_in.cnt  = 16'd1;
    end
    g      = gz_step(gs_in, in_byte, (st_r.mode == MODE_GZIP) && mend, eoi);
    st_nxt = st_r;
    push   = '0;
    unique case (st_r.mode)
      MODE_FIRST: begin
        if (!eoi) begin
          st_nxt.held = in_byte;
          st_nxt.mode = MODE_SECOND;
        end else begin
          st_nxt.mode    = MODE_PLAIN;
          st_nxt.stopped = 1'b1;
          push.n         = 2'd1;
          push.r0        = make_res(st_nxt, in_byte, KIND_PAYLOAD, 1'b0);
        end
      end
      MODE_SECOND: begin
        push.n = 2'd2;
        if (st_r.held == MAGIC0 && in_byte == MAGIC1) begin
          st_nxt.mode = MODE_GZIP;
          push.r0     = make_res(st_nxt, st_r.held, KIND_HEADER, 1'b0);
          st_nxt      = g.s;
          push.r1     = make_res(g.s, in_byte, g.kind, g.done);
        end else begin
          st_nxt.mode    = MODE_PLAIN;
          push.r0        = make_res(st_nxt, st_r.held, KIND_PAYLOAD, 1'b0);
          st_nxt.stopped = eoi;
          push.r1        = make_res(st_nxt, in_byte, KIND_PAYLOAD, 1'b0);
        end
      end
      MODE_GZIP: begin
        st_nxt  = g.s;
        push.n  = 2'd1;
        push.r0 = make_res(g.s, in_byte, g.kind, g.done);
      end
      default: begin
        push.n = 2'd1;
        if (st_r.stopped) begin
          push.r0 = make_res(st_r, in_byte, KIND_DISCARD, 1'b0);
        end else begin
          st_nxt.stopped = eoi;
          push.r0        = make_res(st_nxt, in_byte, KIND_PAYLOAD, 1'b0);
        end
      end
    endcase
    if (push.n == 2'd2) push.r1.last = 1'b1;
    else push.r0.last = 1'b1;
    if (!acc) push.n = 2'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.mode    <= MODE_FIRST;
      st_r.held    <= '0;
      st_r.phase   <= PH_FIXED;
      st_r.cnt     <= '0;
      st_r.flags   <= '0;
      st_r.xlo     <= '0;
      st_r.hvalid  <= 1'b1;
      st_r.stopped <= 1'b0;
    end else if (acc) begin
      st_r <= st_nxt;
    end
  end

  a_pair_only_sniffing: assert property (@(posedge clk) disable iff (!rst_n)
    (push.n == 2'd2) |-> (st_r.mode == MODE_SECOND))
    else $error("two results outside the sniffing pair");

  a_stop_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.stopped |=> st_r.stopped)
    else $error("stopped flag cleared");

  a_gzip_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.mode == MODE_GZIP) |=> (st_r.mode == MODE_GZIP))
    else $error("left gzip mode");

  a_done_to_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (push.n == 2'd1 && push.r0.done) |=> (st_r.phase == PH_PAYLOAD))
    else $error("header completed without entering payload");

endmodule

// ===== rtl/gzmhp_outq.sv =====
// Four-entry result queue that takes up to two results per transaction.
module gzmhp_outq
  import gzmhp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  gzmhp_push_t push,
  input  logic        pop,
  output gzmhp_res_t  head,
  output logic        head_valid,
  output logic        room
);

  gzmhp_res_t     q_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCW-1:0] cnt_r;
  logic           pop_en;

  assign head_valid = (cnt_r != '0);
  assign pop_en     = pop && head_valid;
  assign head       = q_r[rd_ptr_r];
  // Room for the largest burst a single transaction can produce.
  assign room       = (cnt_r <= QCW'(QDEPTH - 2));

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) q_r[wr_ptr_r] <= push.r0;
    if (push.n == 2'd2) q_r[wr_ptr_r + QAW'(1)] <= push.r1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + QAW'(push.n);
      rd_ptr_r <= rd_ptr_r + QAW'(pop_en);
      cnt_r    <= cnt_r + QCW'(push.n) - QCW'(pop_en);
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCW'(QDEPTH))
    else $error("queue count beyond depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push.n != 2'd0) |-> ((QCW + 1)'(cnt_r) + (QCW + 1)'(push.n) <= (QCW + 1)'(QDEPTH)))
    else $error("queue overflow");

  a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_ptr_r - rd_ptr_r) == cnt_r[QAW-1:0])
    else $error("queue pointers disagree with count");

endmodule

// ===== dv/gzip_member_header_parser_tb.sv =====
// Self-checking testbench for the gzip member header parser: directed table, random members.
module gzip_member_header_parser_tb
  import gzmhp_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Stimulus and expectation types. A planned byte may carry hand-written results,
  // in which case typed_n gives their number and the predictor's output is not pushed.
  typedef struct {
    logic [7:0] data;
    logic       mend;
    logic       eoi;
    int         typed_n;
    gzmhp_res_t w0;
    gzmhp_res_t w1;
  } plan_byte_t;

  // Sniffing state and header field being parsed, as the parser sees them.
  typedef enum logic [1:0] {SNIFF_FIRST, SNIFF_SECOND, GZ_MODE, RAW_MODE} sniff_t;
  typedef enum logic [3:0] {
    F_FIXED, F_XLEN_LO, F_XLEN_HI, F_EXTRA, F_NAME, F_COMMENT, F_HCRC, F_PAYLOAD, F_TRAILER
  } field_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;   // data_byte
  logic        in_tuser = 1'b0;    // member_end
  logic        in_tlast = 1'b0;    // end_of_input
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;          // data_out[7:0], member_flags[15:8], status[17:16], zeros
  logic [3:0]  out_tuser;          // byte_kind[1:0], is_plain[2], header_done[3]
  logic        out_tlast;          // last_of_run

  always #5 clk = ~clk;

  gzip_member_header_parser u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  plan_byte_t byte_plan[$];     // every input transaction of the run, in order
  gzmhp_res_t classified_q[$];  // classified bytes still to come out of the block
  int         n_bad = 0;
  bit         quiet = 1'b0;     // no idling on either side in the closing stretch
  bit         hold_req = 1'b0;  // asks the receiver for one long hold-off

  // ---------------------------------------------------------------------------------
  // Predictor: a bit-accurate copy of the parser state, advanced once per accepted
  // input transaction. Its results for that transaction land in step_res[0:step_n-1].
  // ---------------------------------------------------------------------------------
  sniff_t      p_mode;
  logic [7:0]  p_held;
  field_t      p_field;
  logic [15:0] p_cnt;
  logic [7:0]  p_flg;
  logic [7:0]  p_xlo;
  logic        p_hdr_ok;
  logic        p_halted;
  gzmhp_res_t  step_res[2];
  int          step_n;

  // Status once stopped: rejection first, then whether a header (past its first byte)
  // or a trailer was left unfinished.
  function automatic logic [1:0] end_status();
    if (!p_halted) return STAT_RUN;
    if (p_mode != GZ_MODE) return STAT_END_CLEAN;
    if (!p_hdr_ok) return STAT_REJECT;
    if (p_field == F_PAYLOAD || (p_field == F_FIXED && p_cnt == 16'd0)) return STAT_END_CLEAN;
    return STAT_END_OPEN;
  endfunction

  function automatic void note_byte(logic [7:0] b, logic [1:0] k, logic dn);
    step_res[step_n] = '{data: b, kind: k, plain: (p_mode == RAW_MODE), done: dn,
                         flags: p_flg, status: end_status(), last: 1'b0};
    step_n++;
  endfunction

  // Optional header fields follow in a fixed order, each only if its flag is set.
  function automatic field_t field_after(field_t p);
    if (p < F_XLEN_LO && p_flg[FLG_FEXTRA]) return F_XLEN_LO;
    if (p < F_NAME && p_flg[FLG_FNAME]) return F_NAME;
    if (p < F_COMMENT && p_flg[FLG_FCOMMENT]) return F_COMMENT;
    if (p < F_HCRC && p_flg[FLG_FHCRC]) return F_HCRC;
    return F_PAYLOAD;
  endfunction

  // Leaves field p; returns 1 when that completes the header.
  function automatic logic leave_field(field_t p);
    p_field = field_after(p);
    p_cnt = 16'd0;
    return p_field == F_PAYLOAD;
  endfunction

  function automatic void parse_gz_byte(logic [7:0] b, logic mend, logic eoi);
    logic [1:0] k;
    logic       dn;
    k = KIND_HEADER;
    dn = 1'b0;
    if (p_halted) begin
      note_byte(b, KIND_DISCARD, 1'b0);
      return;
    end
    case (p_field) inside
      F_FIXED: begin
        if ((p_cnt == 16'd0 && b != MAGIC0) || (p_cnt == 16'd1 && b != MAGIC1) ||
            (p_cnt == 16'd2 && b != METHOD_DEFLATE))
          p_hdr_ok = 1'b0;
        if (p_cnt == 16'd3) p_flg = b;
        p_cnt++;
        if (p_cnt >= FIXED_LEN) begin
          if (!p_hdr_ok) p_halted = 1'b1;
          else dn = leave_field(F_FIXED);
        end
      end
      F_XLEN_LO: begin
        p_xlo = b;
        p_field = F_XLEN_HI;
      end
      F_XLEN_HI: begin
        p_cnt = {b, p_xlo};
        if (p_cnt == 16'd0) dn = leave_field(F_EXTRA);
        else p_field = F_EXTRA;
      end
      F_EXTRA: begin
        p_cnt--;
        if (p_cnt == 16'd0) dn = leave_field(F_EXTRA);
      end
      F_NAME, F_COMMENT: begin
        if (b == 8'h00) dn = leave_field(p_field);
      end
      F_HCRC: begin
        p_cnt++;
        if (p_cnt >= HCRC_LEN) dn = leave_field(F_HCRC);
      end
      F_TRAILER: begin
        k = KIND_TRAILER;
        p_cnt++;
        if (p_cnt >= TRAILER_LEN) begin
          p_field = F_FIXED;
          p_cnt = 16'd0;
          p_hdr_ok = 1'b1;
        end
      end
      default: begin
        // Payload: the inflater's end mark makes this byte the first of the trailer.
        if (mend) begin
          k = KIND_TRAILER;
          p_field = F_TRAILER;
          p_cnt = 16'd1;
        end else begin
          k = KIND_PAYLOAD;
        end
      end
    endcase
    if (eoi) p_halted = 1'b1;
    note_byte(b, k, dn);
  endfunction

  function automatic void classify_byte(logic [7:0] b, logic mend, logic eoi);
    step_n = 0;
    case (p_mode)
      SNIFF_FIRST: begin
        if (!eoi) begin
          p_held = b;
          p_mode = SNIFF_SECOND;
        end else begin
          p_mode = RAW_MODE;
          p_halted = 1'b1;
          note_byte(b, KIND_PAYLOAD, 1'b0);
        end
      end
      SNIFF_SECOND: begin
        if (p_held == MAGIC0 && b == MAGIC1) begin
          p_mode = GZ_MODE;
          parse_gz_byte(p_held, 1'b0, 1'b0);
          parse_gz_byte(b, 1'b0, eoi);
        end else begin
          p_mode = RAW_MODE;
          note_byte(p_held, KIND_PAYLOAD, 1'b0);
          if (eoi) p_halted = 1'b1;
          note_byte(b, KIND_PAYLOAD, 1'b0);
        end
      end
      GZ_MODE: parse_gz_byte(b, mend, eoi);
      default: begin
        if (p_halted) begin
          note_byte(b, KIND_DISCARD, 1'b0);
        end else begin
          if (eoi) p_halted = 1'b1;
          note_byte(b, KIND_PAYLOAD, 1'b0);
        end
      end
    endcase
    if (step_n > 0) step_res[step_n - 1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------------
  // Stimulus planning.
  // ---------------------------------------------------------------------------------
  function automatic void put(logic [7:0] d, logic m, logic e);
    plan_byte_t s;
    s.data = d;
    s.mend = m;
    s.eoi = e;
    s.typed_n = -1;
    s.w0 = '0;
    s.w1 = '0;
    byte_plan.push_back(s);
  endfunction

  function automatic void put_typed(logic [7:0] d, logic m, logic e, int n,
                                    gzmhp_res_t w0, gzmhp_res_t w1);
    plan_byte_t s;
    s.data = d;
    s.mend = m;
    s.eoi = e;
    s.typed_n = n;
    s.w0 = w0;
    s.w1 = w1;
    byte_plan.push_back(s);
  endfunction

  // Hand-written result of a gzip-mode byte (never plain in this run).
  function automatic gzmhp_res_t gz_res(logic [7:0] d, logic [1:0] k, logic dn,
                                        logic [7:0] f, logic [1:0] st, logic l);
    return '{data: d, kind: k, plain: 1'b0, done: dn, flags: f, status: st, last: l};
  endfunction

  // A stray member_end on a byte where the parser must ignore it.
  function automatic logic stray_mend();
    return $urandom_range(0, 7) == 0;
  endfunction

  // One well-formed member with random flags and contents: header, payload, trailer.
  function automatic void plan_member();
    logic [7:0] flg;
    int         xlen;
    flg = 8'($urandom_range(0, 255));
    put(MAGIC0, stray_mend(), 1'b0);
    put(MAGIC1, stray_mend(), 1'b0);
    put(METHOD_DEFLATE, stray_mend(), 1'b0);
    put(flg, stray_mend(), 1'b0);
    repeat (6) put(8'($urandom_range(0, 255)), stray_mend(), 1'b0);
    if (flg[FLG_FEXTRA]) begin
      // Mostly short extra fields; now and then one that needs the high length byte.
      xlen = ($urandom_range(0, 15) == 0) ? $urandom_range(256, 300) : $urandom_range(0, 12);
      put(xlen[7:0], stray_mend(), 1'b0);
      put(xlen[15:8], stray_mend(), 1'b0);
      repeat (xlen) put(8'($urandom_range(0, 255)), stray_mend(), 1'b0);
    end
    if (flg[FLG_FNAME]) begin
      repeat ($urandom_range(0, 8)) put(8'($urandom_range(1, 255)), stray_mend(), 1'b0);
      put(8'h00, stray_mend(), 1'b0);
    end
    if (flg[FLG_FCOMMENT]) begin
      repeat ($urandom_range(0, 8)) put(8'($urandom_range(1, 255)), stray_mend(), 1'b0);
      put(8'h00, stray_mend(), 1'b0);
    end
    if (flg[FLG_FHCRC])
      repeat (HCRC_LEN) put(8'($urandom_range(0, 255)), stray_mend(), 1'b0);
    repeat ($urandom_range(0, 24)) put(8'($urandom_range(0, 255)), 1'b0, 1'b0);
    put(8'($urandom_range(0, 255)), 1'b1, 1'b0);
    repeat (TRAILER_LEN - 1) put(8'($urandom_range(0, 255)), stray_mend(), 1'b0);
  endfunction

  // ---------------------------------------------------------------------------------
  // Receiver: random stall bursts, one long hold-off on request, none when quiet.
  // ---------------------------------------------------------------------------------
  initial begin : receiver
    bit held_once;
    held_once = 1'b0;
    forever begin
      if (hold_req && !held_once) begin
        // Long enough for the result queue to fill and the input side to stall.
        out_tready <= 1'b0;
        repeat (60) @(posedge clk);
        held_once = 1'b1;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------------------
  // Result checker: every output transaction against the oldest expectation.
  // ---------------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    gzmhp_res_t got;
    gzmhp_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{data: out_tdata[7:0], kind: out_tuser[1:0], plain: out_tuser[2],
              done: out_tuser[3], flags: out_tdata[15:8], status: out_tdata[17:16],
              last: out_tlast};
      if (classified_q.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) begin
          $write("unexpected result: data %02h kind %0d plain %0d done %0d",
                 got.data, got.kind, got.plain, got.done);
          $display(" flags %02h status %0d last %0d", got.flags, got.status, got.last);
        end
      end else begin
        want = classified_q.pop_front();
        if (got != want || out_tdata[23:18] != 6'd0) begin
          n_bad++;
          if (n_bad <= 10) begin
            $write("mismatch: want data %02h kind %0d plain %0d done %0d",
                   want.data, want.kind, want.plain, want.done);
            $display(" flags %02h status %0d last %0d", want.flags, want.status,
                     want.last);
            $write("          got  data %02h kind %0d plain %0d done %0d",
                   got.data, got.kind, got.plain, got.done);
            $display(" flags %02h status %0d last %0d pad %02h", got.flags, got.status,
                     got.last, out_tdata[23:18]);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------------
  // Main sequence: plan the whole file, release reset, send every transaction.
  // ---------------------------------------------------------------------------------
  initial begin : stimulus
    plan_byte_t row;
    plan_byte_t tmp;
    int         n_dir;
    int         s;
    int         cut;
    int         pos;

    p_mode = SNIFF_FIRST;
    p_held = 8'h00;
    p_field = F_FIXED;
    p_cnt = 16'd0;
    p_flg = 8'h00;
    p_xlo = 8'h00;
    p_hdr_ok = 1'b1;
    p_halted = 1'b0;

    // Directed table: one member with every flag set (reserved bits too), a stray
    // member_end in the fixed header, a zero-length extra field, an empty name and
    // comment, and the header CRC. Results that can be read straight off the format
    // are typed in; the rest come from the predictor.
    put_typed(MAGIC0, 1'b0, 1'b0, 0, '0, '0);  // held back while sniffing
    put_typed(MAGIC1, 1'b0, 1'b0, 2,
              gz_res(MAGIC0, KIND_HEADER, 1'b0, 8'h00, STAT_RUN, 1'b0),
              gz_res(MAGIC1, KIND_HEADER, 1'b0, 8'h00, STAT_RUN, 1'b1));
    put(METHOD_DEFLATE, 1'b1, 1'b0);
    put_typed(8'hff, 1'b0, 1'b0, 1,
              gz_res(8'hff, KIND_HEADER, 1'b0, 8'hff, STAT_RUN, 1'b1), '0);
    put(8'h00, 1'b0, 1'b0);
    put(8'h00, 1'b0, 1'b0);
    put(8'h00, 1'b0, 1'b0);
    put(8'h00, 1'b0, 1'b0);
    put(8'hff, 1'b0, 1'b0);
    put(8'h03, 1'b0, 1'b0);
    put(8'h00, 1'b0, 1'b0);  // extra length, low byte
    put(8'h00, 1'b0, 1'b0);  // extra length, high byte: no extra data
    put(8'h00, 1'b0, 1'b0);  // empty name
    put(8'h00, 1'b1, 1'b0);  // empty comment
    put(8'h5a, 1'b0, 1'b0);
    put_typed(8'ha5, 1'b0, 1'b0, 1,
              gz_res(8'ha5, KIND_HEADER, 1'b1, 8'hff, STAT_RUN, 1'b1), '0);
    put_typed(8'hff, 1'b0, 1'b0, 1,
              gz_res(8'hff, KIND_PAYLOAD, 1'b0, 8'hff, STAT_RUN, 1'b1), '0);
    put_typed(8'h00, 1'b1, 1'b0, 1,
              gz_res(8'h00, KIND_TRAILER, 1'b0, 8'hff, STAT_RUN, 1'b1), '0);
    put(8'h01, 1'b0, 1'b0);
    put(8'h02, 1'b1, 1'b0);
    put(8'h04, 1'b0, 1'b0);
    put(8'h10, 1'b0, 1'b0);
    put(8'h20, 1'b0, 1'b0);
    put(8'h40, 1'b0, 1'b0);
    put(8'h80, 1'b0, 1'b0);
    n_dir = byte_plan.size();

    // Random part: back-to-back well-formed members with random contents.
    while (byte_plan.size() < n_dir + 520) plan_member();

    // Since the block stops for good on end of input or a rejected header, the run
    // closes with one random way of stopping: either a header that fails its magic or
    // method check at the tenth byte (end of input there as well, half the time), or
    // end of input on any byte of a last member. A few discarded bytes follow.
    s = byte_plan.size();
    plan_member();
    if ($urandom_range(0, 3) == 0) begin
      pos = $urandom_range(0, 2);
      tmp = byte_plan[s + pos];
      tmp.data = tmp.data ^ (8'h01 << $urandom_range(0, 7));
      byte_plan[s + pos] = tmp;
      cut = s + FIXED_LEN - 1;
      tmp = byte_plan[cut];
      tmp.eoi = 1'($urandom_range(0, 1));
      byte_plan[cut] = tmp;
    end else begin
      cut = $urandom_range(s, byte_plan.size() - 1);
      tmp = byte_plan[cut];
      tmp.eoi = 1'b1;
      byte_plan[cut] = tmp;
    end
    while (byte_plan.size() > cut + 1) void'(byte_plan.pop_back());
    repeat (8)
      put(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    tmp = byte_plan[byte_plan.size() - 1];
    tmp.eoi = 1'b1;
    byte_plan[byte_plan.size() - 1] = tmp;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < byte_plan.size(); i++) begin
      row = byte_plan[i];
      quiet = (i >= byte_plan.size() - 80);
      if (i == n_dir) begin
        // Let the directed member drain completely before the random part starts.
        in_tvalid <= 1'b0;
        do @(posedge clk); while (classified_q.size() != 0);
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
      if (i == n_dir + 40) hold_req = 1'b1;
      in_tvalid <= 1'b1;
      in_tdata <= row.data;
      in_tuser <= row.mend;
      in_tlast <= row.eoi;
      @(posedge clk);
      while (!in_tready) @(posedge clk);
      // Transaction accepted at this edge: advance the predictor and queue its results.
      classify_byte(row.data, row.mend, row.eoi);
      if (row.typed_n >= 0) begin
        if (row.typed_n > 0) classified_q.push_back(row.w0);
        if (row.typed_n > 1) classified_q.push_back(row.w1);
      end else begin
        for (int j = 0; j < step_n; j++) classified_q.push_back(step_res[j]);
      end
    end
    in_tvalid <= 1'b0;

    while (classified_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (n_bad == 0) begin
      $display("gzip_member_header_parser test passed");
    end else begin
      $display("gzip_member_header_parser test failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin : watchdog
    #3_000_000;
    $display("gzip_member_header_parser test failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/gzmhp_pkg.sv
rtl/gzmhp_core.sv
rtl/gzmhp_outq.sv
rtl/gzip_member_header_parser.sv
dv/gzip_member_header_parser_tb.sv
